// ----- sv/ptb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ptb_pkg;

   // vertex table
   localparam int VERTEX_COUNT = 1024;
   localparam int VTX_AW       = $clog2(VERTEX_COUNT);

   // datapath widths
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   localparam int CROSS_W = 2 * DIFF_W + 1;
   localparam int MUL_B_W = DIFF_W;
   localparam int PROD_W  = CROSS_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int NUM2_W  = ACC_W + 2;
   localparam int DIV_W   = NUM2_W + 1;
   localparam int WGT_W   = 16;
   localparam int QUO_W   = WGT_W;
   localparam int FRAC_SH = 14;

   // queue between front and back
   localparam int QDEPTH = 2;
   localparam int QP_W   = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
   } vec_type;

   typedef struct packed {
      logic                     func;
      vec_type                  p;
      vec_type                  n;
      vec_type                  va;
      vec_type                  vb;
      vec_type                  vc;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic                     inside_res;
      logic [15:0]              distance;
      logic signed [WGT_W-1:0]  bary_0;
      logic signed [WGT_W-1:0]  bary_1;
      logic signed [WGT_W-1:0]  bary_2;
      logic                     degenerate;
   } rsp_type;

endpackage
`default_nettype wire

// ----- sv/ptb_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface ptb_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic [9:0]         vertex_index;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] coord_z;
   logic [9:0]         vertex_a;
   logic [9:0]         vertex_b;
   logic [9:0]         vertex_c;
   logic signed [15:0] normal_x;
   logic signed [15:0] normal_y;
   logic signed [15:0] normal_z;

   modport source (output valid, func, vertex_index, coord_x, coord_y, coord_z,
                   vertex_a, vertex_b, vertex_c, normal_x, normal_y, normal_z,
                   input ready);
   modport sink (input valid, func, vertex_index, coord_x, coord_y, coord_z,
                 vertex_a, vertex_b, vertex_c, normal_x, normal_y, normal_z,
                 output ready);
endinterface

interface ptb_rsp_if;
   logic               valid;
   logic               ready;
   logic               inside_res;
   logic [15:0]        distance;
   logic signed [15:0] bary_0;
   logic signed [15:0] bary_1;
   logic signed [15:0] bary_2;
   logic               degenerate;

   modport source (output valid, inside_res, distance, bary_0, bary_1, bary_2,
                   degenerate, input ready);
   modport sink (input valid, inside_res, distance, bary_0, bary_1, bary_2,
                 degenerate, output ready);
endinterface
`default_nettype wire

// ----- sv/ptb_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ptb_div import ptb_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic signed [NUM2_W-1:0] num,
   input  wire logic signed [ACC_W-1:0]  den,
   output logic                          done,
   output logic signed [WGT_W-1:0]       weight
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [3:0]           cnt_ff;
   logic [DIV_W-1:0]     r_ff;
   logic [DIV_W-1:0]     b_ff;
   logic [QUO_W-1:0]     q_ff;
   logic                 neg_ff;
   logic                 sat_ff;

   logic [DIV_W-1:0]     a_abs;
   logic [DIV_W-1:0]     b_abs;
   logic [DIV_W-1:0]     trial;
   logic [QUO_W-1:0]     q_sh;
   logic [QUO_W:0]       mag;

   // operand magnitudes
   always_comb begin
      a_abs = num[NUM2_W-1] ? DIV_W'(-num) : DIV_W'(num);
      b_abs = den[ACC_W-1] ? DIV_W'(-den) : DIV_W'(den);
   end

   // first step compares unshifted, later steps shift one bit in
   always_comb begin
      trial = (cnt_ff == '0) ? r_ff : {r_ff[DIV_W-2:0], 1'b0};
      q_sh  = (cnt_ff == '0) ? q_ff : {q_ff[QUO_W-2:0], 1'b0};
   end

   // restoring divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 4'd1;
            if (cnt_ff == 4'(QUO_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         r_ff   <= a_abs;
         b_ff   <= b_abs;
         q_ff   <= '0;
         neg_ff <= num[NUM2_W-1] ^ den[ACC_W-1];
         sat_ff <= a_abs >= {b_abs[DIV_W-2:0], 1'b0};
      end else if (busy_ff) begin
         if (trial >= b_ff) begin
            r_ff <= trial - b_ff;
            q_ff <= q_sh | QUO_W'(1);
         end else begin
            r_ff <= trial;
            q_ff <= q_sh;
         end
      end
   end

   // round half away from zero, then saturate
   always_comb begin
      mag = sat_ff ? {1'b1, {QUO_W{1'b0}}} : (({1'b0, q_ff} + (QUO_W+1)'(1)) >> 1);
      if (neg_ff) begin
         weight = (mag > (QUO_W+1)'(32768)) ? -16'sd32768 : WGT_W'(-$signed(mag));
      end else begin
         weight = (mag > (QUO_W+1)'(32767)) ? 16'sd32767 : WGT_W'(mag);
      end
   end

   assign done = done_ff;

   a_div_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff) else $error("divider restarted while busy");

endmodule
`default_nettype wire

// ----- sv/ptb_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ptb_front import ptb_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ptb_req_if.sink     req_ch,
   output head_type    head,
   input  wire logic   pop
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_RD_A = 4'b0010,
      F_RD_B = 4'b0100,
      F_RD_C = 4'b1000
   } fstate_type;

   fstate_type          state_ff, state_in;
   entry_type           item_ff, item_in;
   logic [VTX_AW-1:0]   idx_b_ff, idx_b_in;
   logic [VTX_AW-1:0]   idx_c_ff, idx_c_in;
   logic [VTX_AW-1:0]   rd_addr;
   vec_type             rd_ff;
   vec_type             mem [VERTEX_COUNT];

   entry_type           q_ff [QDEPTH];
   logic [QP_W-1:0]     wp_ff;
   logic [QP_W-1:0]     rp_ff;
   logic [QCNT_W-1:0]   cnt_ff;
   logic                q_space;
   logic                accept;
   logic                push;
   entry_type           push_entry;

   assign q_space      = cnt_ff != QCNT_W'(QDEPTH);
   assign req_ch.ready = (state_ff == F_IDLE) && q_space;
   assign accept       = req_ch.valid && req_ch.ready;

   // accept, then fetch the three corners one per cycle
   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      idx_b_in   = idx_b_ff;
      idx_c_in   = idx_c_ff;
      push       = 1'b0;
      push_entry = item_ff;
      rd_addr    = idx_c_ff;
      unique case (state_ff)
         F_IDLE: begin
            rd_addr = req_ch.vertex_a;
            if (accept) begin
               if (req_ch.func == FUNC_QUERY) begin
                  item_in.func = FUNC_QUERY;
                  item_in.p    = '{req_ch.coord_x, req_ch.coord_y, req_ch.coord_z};
                  item_in.n    = '{req_ch.normal_x, req_ch.normal_y, req_ch.normal_z};
                  idx_b_in     = req_ch.vertex_b;
                  idx_c_in     = req_ch.vertex_c;
                  state_in     = F_RD_A;
               end else begin
                  push       = 1'b1;
                  push_entry = '0;
               end
            end
         end
         F_RD_A: begin
            rd_addr    = idx_b_ff;
            item_in.va = rd_ff;
            state_in   = F_RD_B;
         end
         F_RD_B: begin
            item_in.vb = rd_ff;
            state_in   = F_RD_C;
         end
         F_RD_C: begin
            push_entry.vc = rd_ff;
            if (q_space) begin
               push     = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      idx_b_ff <= idx_b_in;
      idx_c_ff <= idx_c_in;
   end

   // vertex table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (accept && (req_ch.func == FUNC_WRITE)) begin
         mem[req_ch.vertex_index] <= '{req_ch.coord_x, req_ch.coord_y, req_ch.coord_z};
      end
      rd_ff <= mem[rd_addr];
   end

   // queue toward the back part
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + QP_W'(1);
         end
         if (pop) begin
            rp_ff <= rp_ff + QP_W'(1);
         end
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
      end
   end

   assign head.valid = cnt_ff != '0;
   assign head.entry = q_ff[rp_ff];

   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH)) else $error("queue overfilled");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> cnt_ff != '0) else $error("pop from empty queue");

endmodule
`default_nettype wire

// ----- sv/ptb_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ptb_back import ptb_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire head_type head,
   output logic          pop,
   ptb_rsp_if.source     rsp_ch
);

   typedef enum logic [4:0] {
      B_IDLE = 5'b00001,
      B_MAC  = 5'b00010,
      B_NUM2 = 5'b00100,
      B_DIV  = 5'b01000,
      B_OUT  = 5'b10000
   } bstate_type;

   typedef enum logic [3:0] {
      K_CX_SET, K_CX_SUB, K_CY_SET, K_CY_SUB, K_CZ_SET, K_CZ_SUB,
      K_T_SET, K_T_ADD, K_T_FIN
   } kind_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] x;
      logic signed [DIFF_W-1:0] y;
      logic signed [DIFF_W-1:0] z;
   } dvec_type;

   function automatic dvec_type dsub(input vec_type a, input vec_type b);
      dvec_type r;
      r.x = DIFF_W'(a.x) - DIFF_W'(b.x);
      r.y = DIFF_W'(a.y) - DIFF_W'(b.y);
      r.z = DIFF_W'(a.z) - DIFF_W'(b.z);
      return r;
   endfunction

   bstate_type                 state_ff, state_in;
   logic [1:0]                 tri_ff;
   logic [3:0]                 sub_ff;
   logic                       wr_ff;
   logic                       op_vld_ff;
   kind_type                   op_kind_ff;
   logic [1:0]                 op_dst_ff;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [CROSS_W-1:0]  cx_ff, cy_ff, cz_ff;
   logic signed [ACC_W-1:0]    t_ff;
   logic signed [ACC_W-1:0]    area_ff, num0_ff, num1_ff, d_ff;
   logic signed [NUM2_W-1:0]   num2_ff;
   logic signed [WGT_W-1:0]    w0_ff, w1_ff, w2_ff;
   logic [1:0]                 sel_ff;
   logic                       issue_ff;
   logic                       rsp_vld_ff;
   rsp_type                    rsp_ff;

   dvec_type                   u, w, pa;
   vec_type                    n;
   logic signed [CROSS_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   kind_type                   kind;
   logic                       last_step;
   logic                       div_start, div_done;
   logic signed [NUM2_W-1:0]   div_num;
   logic signed [WGT_W-1:0]    div_w;
   logic                       load;
   logic                       degen;
   logic                       in_tri;
   logic [ACC_W-1:0]           d_mag;
   logic [ACC_W:0]             d_rnd;
   logic                       n0_le, n1_le, n2_le, n0_ge, n1_ge, n2_ge;

   // edge vectors of the current triple product
   always_comb begin
      n  = head.entry.n;
      pa = dsub(head.entry.p, head.entry.va);
      case (tri_ff)
         2'd0: begin
            u = dsub(head.entry.vb, head.entry.va);
            w = dsub(head.entry.vc, head.entry.va);
         end
         2'd1: begin
            u = dsub(head.entry.vc, head.entry.vb);
            w = dsub(head.entry.p, head.entry.vb);
         end
         default: begin
            u = dsub(head.entry.va, head.entry.vc);
            w = dsub(head.entry.p, head.entry.vc);
         end
      endcase
   end

   // operand schedule: six cross terms then three normal terms per triple,
   // plane distance last
   always_comb begin
      mul_a = CROSS_W'(pa.x);
      mul_b = MUL_B_W'(n.x);
      kind  = K_T_SET;
      if (tri_ff == 2'd3) begin
         unique case (sub_ff)
            4'd0: begin mul_a = CROSS_W'(pa.x); mul_b = MUL_B_W'(n.x); kind = K_T_SET; end
            4'd1: begin mul_a = CROSS_W'(pa.y); mul_b = MUL_B_W'(n.y); kind = K_T_ADD; end
            default: begin
               mul_a = CROSS_W'(pa.z); mul_b = MUL_B_W'(n.z); kind = K_T_FIN;
            end
         endcase
      end else begin
         unique case (sub_ff)
            4'd0: begin mul_a = CROSS_W'(u.y); mul_b = w.z; kind = K_CX_SET; end
            4'd1: begin mul_a = CROSS_W'(u.z); mul_b = w.y; kind = K_CX_SUB; end
            4'd2: begin mul_a = CROSS_W'(u.z); mul_b = w.x; kind = K_CY_SET; end
            4'd3: begin mul_a = CROSS_W'(u.x); mul_b = w.z; kind = K_CY_SUB; end
            4'd4: begin mul_a = CROSS_W'(u.x); mul_b = w.y; kind = K_CZ_SET; end
            4'd5: begin mul_a = CROSS_W'(u.y); mul_b = w.x; kind = K_CZ_SUB; end
            4'd6: begin mul_a = cx_ff; mul_b = MUL_B_W'(n.x); kind = K_T_SET; end
            4'd7: begin mul_a = cy_ff; mul_b = MUL_B_W'(n.y); kind = K_T_ADD; end
            default: begin mul_a = cz_ff; mul_b = MUL_B_W'(n.z); kind = K_T_FIN; end
         endcase
      end
   end

   assign last_step = (tri_ff == 2'd3) && (sub_ff == 4'd2);

   // multiply stage
   always_ff @(posedge clock) begin
      prod_ff    <= mul_a * mul_b;
      op_kind_ff <= kind;
      op_dst_ff  <= tri_ff;
   end

   // accumulate stage
   always_ff @(posedge clock) begin
      if (op_vld_ff) begin
         unique case (op_kind_ff)
            K_CX_SET: cx_ff <= CROSS_W'(prod_ff);
            K_CX_SUB: cx_ff <= cx_ff - CROSS_W'(prod_ff);
            K_CY_SET: cy_ff <= CROSS_W'(prod_ff);
            K_CY_SUB: cy_ff <= cy_ff - CROSS_W'(prod_ff);
            K_CZ_SET: cz_ff <= CROSS_W'(prod_ff);
            K_CZ_SUB: cz_ff <= cz_ff - CROSS_W'(prod_ff);
            K_T_SET:  t_ff  <= ACC_W'(prod_ff);
            K_T_ADD:  t_ff  <= t_ff + ACC_W'(prod_ff);
            K_T_FIN: begin
               unique case (op_dst_ff)
                  2'd0:    area_ff <= t_ff + ACC_W'(prod_ff);
                  2'd1:    num0_ff <= t_ff + ACC_W'(prod_ff);
                  2'd2:    num1_ff <= t_ff + ACC_W'(prod_ff);
                  default: d_ff    <= t_ff + ACC_W'(prod_ff);
               endcase
            end
            default: t_ff <= t_ff;
         endcase
      end
      if (state_ff == B_NUM2) begin
         num2_ff <= NUM2_W'(area_ff) - NUM2_W'(num0_ff) - NUM2_W'(num1_ff);
      end
   end

   // shared divider for the three weights
   always_comb begin
      case (sel_ff)
         2'd0:    div_num = NUM2_W'(num0_ff);
         2'd1:    div_num = NUM2_W'(num1_ff);
         default: div_num = num2_ff;
      endcase
   end

   assign div_start = (state_ff == B_DIV) && issue_ff;

   ptb_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (div_num),
      .den    (area_ff),
      .done   (div_done),
      .weight (div_w)
   );

   always_ff @(posedge clock) begin
      if (div_done) begin
         case (sel_ff)
            2'd0:    w0_ff <= div_w;
            2'd1:    w1_ff <= div_w;
            default: w2_ff <= div_w;
         endcase
      end
   end

   // result fields
   always_comb begin
      degen = !wr_ff && (area_ff == '0);
      n0_le = num0_ff[ACC_W-1] || (num0_ff == '0);
      n1_le = num1_ff[ACC_W-1] || (num1_ff == '0);
      n2_le = num2_ff[NUM2_W-1] || (num2_ff == '0);
      n0_ge = !num0_ff[ACC_W-1];
      n1_ge = !num1_ff[ACC_W-1];
      n2_ge = !num2_ff[NUM2_W-1];
      in_tri = !wr_ff && !degen &&
               (area_ff[ACC_W-1] ? (n0_le && n1_le && n2_le) : (n0_ge && n1_ge && n2_ge));
      d_mag  = d_ff[ACC_W-1] ? ACC_W'(-d_ff) : ACC_W'(d_ff);
      d_rnd  = {1'b0, d_mag} + (ACC_W+1)'(1 << (FRAC_SH - 1));
   end

   assign load = (state_ff == B_OUT) && (!rsp_vld_ff || rsp_ch.ready);
   assign pop  = load;

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (head.valid) begin
               state_in = (head.entry.func == FUNC_QUERY) ? B_MAC : B_OUT;
            end
         end
         B_MAC:  if (last_step) state_in = B_NUM2;
         B_NUM2: state_in = (area_ff == '0) ? B_OUT : B_DIV;
         B_DIV:  if (div_done && (sel_ff == 2'd2)) state_in = B_OUT;
         B_OUT:  if (load) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= B_IDLE;
         tri_ff     <= '0;
         sub_ff     <= '0;
         op_vld_ff  <= 1'b0;
         sel_ff     <= '0;
         issue_ff   <= 1'b0;
         wr_ff      <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         op_vld_ff <= state_ff == B_MAC;
         issue_ff  <= 1'b0;
         if (state_ff == B_IDLE) begin
            tri_ff <= '0;
            sub_ff <= '0;
            wr_ff  <= head.entry.func == FUNC_WRITE;
         end
         if (state_ff == B_MAC) begin
            if ((sub_ff == 4'd8) && (tri_ff != 2'd3)) begin
               sub_ff <= '0;
               tri_ff <= tri_ff + 2'd1;
            end else begin
               sub_ff <= sub_ff + 4'd1;
            end
         end
         if (state_ff == B_NUM2) begin
            sel_ff   <= '0;
            issue_ff <= area_ff != '0;
         end
         if (div_done && (sel_ff != 2'd2)) begin
            sel_ff   <= sel_ff + 2'd1;
            issue_ff <= 1'b1;
         end
         if (load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff.inside_res <= in_tri;
         rsp_ff.distance   <= !in_tri ? 16'd0 :
                              (|d_rnd[ACC_W:FRAC_SH+16]) ? 16'hFFFF :
                              d_rnd[FRAC_SH+15:FRAC_SH];
         rsp_ff.bary_0     <= (wr_ff || degen) ? '0 : w0_ff;
         rsp_ff.bary_1     <= (wr_ff || degen) ? '0 : w1_ff;
         rsp_ff.bary_2     <= (wr_ff || degen) ? '0 : w2_ff;
         rsp_ff.degenerate <= degen;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.inside_res = rsp_ff.inside_res;
   assign rsp_ch.distance   = rsp_ff.distance;
   assign rsp_ch.bary_0     = rsp_ff.bary_0;
   assign rsp_ch.bary_1     = rsp_ff.bary_1;
   assign rsp_ch.bary_2     = rsp_ff.bary_2;
   assign rsp_ch.degenerate = rsp_ff.degenerate;

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_DIV |-> area_ff != '0) else $error("divide by zero area");
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == B_DIV) else $error("divider done outside divide");

endmodule
`default_nettype wire

// ----- sv/point_triangle_barycentric.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel   dir   handshake           payload
// req_ch    in    valid / ready       func, vertex_index, coord_x/y/z, vertex_a/b/c, normal_x/y/z
// rsp_ch    out   valid / ready       inside_res, distance, bary_0/1/2, degenerate
//
// a query takes 3 table reads, 30 steps of the single shared multiplier and three
// passes of the radix-2 divider; the multiplier steps and divider passes set the rate.
// reset is synchronous; the vertex table is not cleared.
// a queue of two transactions lets the front take and fetch the next item
// while the back computes, and the output register holds a stalled result.
module point_triangle_barycentric import ptb_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   ptb_req_if.sink     req_ch,
   ptb_rsp_if.source   rsp_ch
);

   head_type head;
   logic     pop;

   ptb_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   ptb_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
`default_nettype wire

// ----- tb/point_triangle_barycentric_chk.sv -----
`timescale 1ns / 1ps
module point_triangle_barycentric_chk import ptb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ptb_req_if        req,
   ptb_rsp_if        rsp,
   output int        fail_count,
   output int        pending
);

   // local copy of the vertex table, only entries the stimulus wrote are read
   vec_type vertices [VERTEX_COUNT];
   rsp_type expected_rsp [$];

   function automatic longint triple_dot(input longint u[3], input longint w[3],
                                         input longint n[3]);
      longint cx, cy, cz;
      cx = u[1] * w[2] - u[2] * w[1];
      cy = u[2] * w[0] - u[0] * w[2];
      cz = u[0] * w[1] - u[1] * w[0];
      return cx * n[0] + cy * n[1] + cz * n[2];
   endfunction

   // num / den in q1.14, rounded half away from zero, saturated
   function automatic logic signed [15:0] weight_q14(input longint num, input longint den);
      bit                neg;
      longint unsigned   a, b, q, r, mag;
      longint            val;
      neg = (num < 0) != (den < 0);
      a = (num < 0) ? -num : num;
      b = (den < 0) ? -den : den;
      q = a / b;
      r = a % b;
      if (q >= 2) begin
         mag = 65536;
      end else begin
         for (int i = 0; i < 15; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= b) begin
               r = r - b;
               q = q | 1;
            end
         end
         mag = (q + 1) >> 1;
      end
      val = neg ? -longint'(mag) : longint'(mag);
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
      return val[15:0];
   endfunction

   function automatic rsp_type predict_query(input vec_type pt, input vec_type nv,
                                             input vec_type a, input vec_type b,
                                             input vec_type c);
      rsp_type          res;
      longint           p[3], n[3], va[3], vb[3], vc[3];
      longint           ab[3], ac[3], cb[3], pb[3], ca[3], pc[3];
      longint           d, area, num0, num1, num2;
      longint unsigned  mag, dist_q;
      res = '0;
      p  = '{pt.x, pt.y, pt.z};
      n  = '{nv.x, nv.y, nv.z};
      va = '{a.x, a.y, a.z};
      vb = '{b.x, b.y, b.z};
      vc = '{c.x, c.y, c.z};
      for (int k = 0; k < 3; k++) begin
         ab[k] = vb[k] - va[k];
         ac[k] = vc[k] - va[k];
         cb[k] = vc[k] - vb[k];
         pb[k] = p[k] - vb[k];
         ca[k] = va[k] - vc[k];
         pc[k] = p[k] - vc[k];
      end
      d = (p[0] - va[0]) * n[0] + (p[1] - va[1]) * n[1] + (p[2] - va[2]) * n[2];
      area = triple_dot(ab, ac, n);
      num0 = triple_dot(cb, pb, n);
      num1 = triple_dot(ca, pc, n);
      num2 = area - num0 - num1;
      if (area == 0) begin
         res.degenerate = 1'b1;
      end else begin
         res.bary_0 = weight_q14(num0, area);
         res.bary_1 = weight_q14(num1, area);
         res.bary_2 = weight_q14(num2, area);
         if (area > 0)
            res.inside_res = num0 >= 0 && num1 >= 0 && num2 >= 0;
         else
            res.inside_res = num0 <= 0 && num1 <= 0 && num2 <= 0;
         if (res.inside_res) begin
            mag = (d < 0) ? -d : d;
            dist_q = (mag + 8192) >> 14;
            if (dist_q > 65535) dist_q = 65535;
            res.distance = dist_q[15:0];
         end
      end
      return res;
   endfunction

   assign pending = expected_rsp.size();

   // predict on each accepted request transaction
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready) begin
         if (req.func == FUNC_WRITE) begin
            vertices[req.vertex_index] <= '{req.coord_x, req.coord_y, req.coord_z};
            expected_rsp.push_back('0);
         end else begin
            expected_rsp.push_back(predict_query('{req.coord_x, req.coord_y, req.coord_z},
                                                 '{req.normal_x, req.normal_y, req.normal_z},
                                                 vertices[req.vertex_a],
                                                 vertices[req.vertex_b],
                                                 vertices[req.vertex_c]));
         end
      end
   end

   // compare each accepted response transaction
   initial fail_count = 0;
   always @(posedge clock) begin
      rsp_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_rsp.size() == 0) begin
            $error("response transaction with none expected");
            fail_count++;
         end else begin
            exp_r = expected_rsp.pop_front();
            if (rsp.inside_res !== exp_r.inside_res) begin
               $error("inside_res expected %0d actual %0d", exp_r.inside_res, rsp.inside_res);
               fail_count++;
            end
            if (rsp.distance !== exp_r.distance) begin
               $error("distance expected %0d actual %0d", exp_r.distance, rsp.distance);
               fail_count++;
            end
            if (rsp.bary_0 !== exp_r.bary_0) begin
               $error("bary_0 expected %0d actual %0d", exp_r.bary_0, rsp.bary_0);
               fail_count++;
            end
            if (rsp.bary_1 !== exp_r.bary_1) begin
               $error("bary_1 expected %0d actual %0d", exp_r.bary_1, rsp.bary_1);
               fail_count++;
            end
            if (rsp.bary_2 !== exp_r.bary_2) begin
               $error("bary_2 expected %0d actual %0d", exp_r.bary_2, rsp.bary_2);
               fail_count++;
            end
            if (rsp.degenerate !== exp_r.degenerate) begin
               $error("degenerate expected %0d actual %0d", exp_r.degenerate, rsp.degenerate);
               fail_count++;
            end
         end
      end
   end

endmodule

// ----- tb/point_triangle_barycentric_tb.sv -----
`timescale 1ns / 1ps
module point_triangle_barycentric_tb import ptb_pkg::*;;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   idle_pct;
   int   stall_pct;
   bit   written [VERTEX_COUNT];
   int   written_list [$];

   ptb_req_if req_ch ();
   ptb_rsp_if rsp_ch ();

   point_triangle_barycentric i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   point_triangle_barycentric_chk i_chk (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .rsp        (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // drive one request transaction, wait for its acceptance
   task automatic send(input logic func, input logic [9:0] idx,
                       input logic signed [15:0] x, y, z,
                       input logic [9:0] a, b, c,
                       input logic signed [15:0] nx, ny, nz);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.func         <= func;
      req_ch.vertex_index <= idx;
      req_ch.coord_x      <= x;
      req_ch.coord_y      <= y;
      req_ch.coord_z      <= z;
      req_ch.vertex_a     <= a;
      req_ch.vertex_b     <= b;
      req_ch.vertex_c     <= c;
      req_ch.normal_x     <= nx;
      req_ch.normal_y     <= ny;
      req_ch.normal_z     <= nz;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic write_vertex(input logic [9:0] idx, input logic signed [15:0] x, y, z);
      send(FUNC_WRITE, idx, x, y, z, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom);
      if (!written[idx]) written_list.push_back(idx);
      written[idx] = 1'b1;
   endtask

   task automatic query(input logic signed [15:0] x, y, z, input logic [9:0] a, b, c,
                        input logic signed [15:0] nx, ny, nz);
      send(FUNC_QUERY, $urandom, x, y, z, a, b, c, nx, ny, nz);
   endtask

   function automatic logic signed [15:0] rand_coord();
      if ($urandom_range(3) == 0)
         return $urandom;
      return $signed($urandom_range(16000)) - 8000;
   endfunction

   function automatic logic signed [15:0] rand_normal();
      return $signed($urandom_range(32768)) - 16384;
   endfunction

   function automatic logic [9:0] pick_written();
      return written_list[$urandom_range(written_list.size() - 1)];
   endfunction

   // a random triangle and a point near it, mostly inside
   task automatic random_triangle_query();
      logic [9:0]         ia, ib, ic;
      logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz, nx, ny, nz;
      int                 px, py, pz, off, axis;
      ia = $urandom; ib = $urandom; ic = $urandom;
      ax = $signed($urandom_range(16000)) - 8000;
      ay = $signed($urandom_range(16000)) - 8000;
      bx = $signed($urandom_range(16000)) - 8000;
      by = $signed($urandom_range(16000)) - 8000;
      cx = $signed($urandom_range(16000)) - 8000;
      cy = $signed($urandom_range(16000)) - 8000;
      az = $signed($urandom_range(400)) - 200;
      bz = $signed($urandom_range(400)) - 200;
      cz = $signed($urandom_range(400)) - 200;
      write_vertex(ia, ax, ay, az);
      write_vertex(ib, bx, by, bz);
      write_vertex(ic, cx, cy, cz);
      px = (ax + bx + cx) / 3;
      py = (ay + by + cy) / 3;
      pz = (az + bz + cz) / 3;
      off = $signed($urandom_range(16000)) - 8000;
      axis = $urandom_range(3);
      nx = 0; ny = 0; nz = ($urandom_range(1) != 0) ? 16384 : -16384;
      if (axis == 3) begin
         nx = rand_normal(); ny = rand_normal(); nz = rand_normal();
      end
      if ($urandom_range(4) == 0) begin
         px = px + $signed($urandom_range(20000)) - 10000;
         py = py + $signed($urandom_range(20000)) - 10000;
      end
      pz = pz + off;
      if (pz > 32767) pz = 32767;
      if (pz < -32768) pz = -32768;
      if (px > 32767) px = 32767;
      if (px < -32768) px = -32768;
      if (py > 32767) py = 32767;
      if (py < -32768) py = -32768;
      query(px, py, pz, ia, ib, ic, nx, ny, nz);
   endtask

   initial begin
      int seq;
      idle_pct  = 0;
      stall_pct = 0;
      reset     = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.func         = FUNC_WRITE;
      req_ch.vertex_index = '0;
      req_ch.coord_x      = '0;
      req_ch.coord_y      = '0;
      req_ch.coord_z      = '0;
      req_ch.vertex_a     = '0;
      req_ch.vertex_b     = '0;
      req_ch.vertex_c     = '0;
      req_ch.normal_x     = '0;
      req_ch.normal_y     = '0;
      req_ch.normal_z     = '0;
      rsp_ch.ready        = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, degenerate, non-unit normal, inside and outside
      write_vertex(10'd0, 16'sd0, 16'sd0, 16'sd0);
      write_vertex(10'd1, 16'sd2560, 16'sd0, 16'sd0);
      write_vertex(10'd2, 16'sd0, 16'sd2560, 16'sd0);
      write_vertex(10'd1023, 16'sh7fff, 16'sh7fff, 16'sh7fff);
      write_vertex(10'd512, -16'sh8000, -16'sh8000, -16'sh8000);
      write_vertex(10'd3, 16'sh7fff, -16'sh8000, 16'sd0);
      query(16'sd512, 16'sd512, 16'sd256, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd16384);
      query(16'sd512, 16'sd512, -16'sd256, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, -16'sd16384);
      query(16'sd5000, 16'sd5000, 16'sd0, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd16384);
      query(16'sd0, 16'sd0, 16'sd0, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd16384);
      query(16'sd100, 16'sd100, 16'sd100, 10'd1, 10'd1, 10'd1, 16'sd0, 16'sd0, 16'sd16384);
      query(16'sd100, 16'sd100, 16'sd100, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd0);
      query(16'sd300, 16'sd300, 16'sd900, 10'd0, 10'd1, 10'd2, 16'sd3000, -16'sd7000,
            16'sd5000);
      query(16'sh7fff, 16'sh7fff, 16'sh7fff, 10'd1023, 10'd512, 10'd3,
            16'sd16384, 16'sd16384, 16'sd16384);
      query(-16'sh8000, -16'sh8000, -16'sh8000, 10'd512, 10'd3, 10'd1023,
            -16'sd16384, -16'sd16384, -16'sd16384);
      query(16'sh7fff, -16'sh8000, 16'sh7fff, 10'd3, 10'd1023, 10'd0,
            -16'sd16384, 16'sd16384, -16'sd16384);
      query(16'sd512, 16'sd512, 16'sd0, 10'd0, 10'd2, 10'd1, 16'sd0, 16'sd0, 16'sd16384);
      query(16'sd1280, 16'sd1280, 16'sd0, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd16384);
      query(16'sd2560, 16'sd0, 16'sd0, 10'd0, 10'd1, 10'd2, 16'sd0, 16'sd0, 16'sd16384);

      // random phases with different idle and stall rates
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 88; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 88; end
            default: begin idle_pct = 20; stall_pct = 20; end
         endcase
         seq = 0;
         while (seq < 390) begin
            case ($urandom_range(9))
               0, 1, 2, 3, 4, 5: begin
                  random_triangle_query();
                  seq += 4;
               end
               6: begin
                  write_vertex($urandom, rand_coord(), rand_coord(), rand_coord());
                  seq++;
               end
               default: begin
                  query(rand_coord(), rand_coord(), rand_coord(), pick_written(),
                        pick_written(), pick_written(), rand_normal(), rand_normal(),
                        rand_normal());
                  seq++;
               end
            endcase
            // hold off the sender until the block drains
            if (phase == 1 && seq >= 200 && seq < 205) begin
               req_ch.valid <= 1'b0;
               @(posedge clock);
               while (pending != 0) @(posedge clock);
            end
         end
      end
      req_ch.valid <= 1'b0;
      stall_pct = 0;

      // drain and let the pipeline settle
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("point_triangle_barycentric_tb OK");
      else
         $display("point_triangle_barycentric_tb NOT OK");
      $finish;
   end

   // watchdog
   initial begin
      #30_000_000;
      $display("point_triangle_barycentric_tb NOT OK");
      $finish;
   end

endmodule
